@@ rtl/dtp_pkg.sv @@
`default_nettype none
package dtp_pkg;

  // widths of the character stream and of the result
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned FIELD_W = 7;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned VALUE_W = 47;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned YEAR_DIGITS = 4;

  // string layout YYYY-MM-DD hh:mm:ss
  localparam logic [POS_W-1:0] STR_LEN    = 5'd19;
  localparam logic [POS_W-1:0] POS_LAST   = 5'd18;
  localparam logic [POS_W-1:0] POS_MAX    = 5'd31;
  localparam logic [POS_W-1:0] POS_YEAR_E = 5'd3;
  localparam logic [POS_W-1:0] POS_DASH1  = 5'd4;
  localparam logic [POS_W-1:0] POS_MON_E  = 5'd6;
  localparam logic [POS_W-1:0] POS_DASH2  = 5'd7;
  localparam logic [POS_W-1:0] POS_DAY_E  = 5'd9;
  localparam logic [POS_W-1:0] POS_SPACE  = 5'd10;
  localparam logic [POS_W-1:0] POS_HOUR_E = 5'd12;
  localparam logic [POS_W-1:0] POS_COLON1 = 5'd13;
  localparam logic [POS_W-1:0] POS_MIN_E  = 5'd15;
  localparam logic [POS_W-1:0] POS_COLON2 = 5'd16;

  // character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

  // field limits
  localparam logic [FIELD_W-1:0] MONTH_MAX  = 7'd12;
  localparam logic [FIELD_W-1:0] HOUR_MAX   = 7'd23;
  localparam logic [FIELD_W-1:0] MINSEC_MAX = 7'd59;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_FORMAT = 3'd1,
    ST_YEAR   = 3'd2,
    ST_MONTH  = 3'd3,
    ST_DAY    = 3'd4,
    ST_TIME   = 3'd5
  } status_e;

  // fields of one finished string, handed from the scanner to the checker
  typedef struct packed {
    logic                                  fmt_bad;
    logic [YEAR_DIGITS-1:0][DIGIT_W-1:0]   year_dig;
    logic [FIELD_W-1:0]                    month;
    logic [FIELD_W-1:0]                    day;
    logic [FIELD_W-1:0]                    hour;
    logic [FIELD_W-1:0]                    minute;
    logic [FIELD_W-1:0]                    second;
    logic [VALUE_W-1:0]                    value;
  } snap_t;

  // shift one decimal digit into a two-digit field
  function automatic logic [FIELD_W-1:0] push_digit(input logic [FIELD_W-1:0] acc,
                                                   input logic [DIGIT_W-1:0] dig);
    push_digit = FIELD_W'(acc * 7'd10) + FIELD_W'(dig);
  endfunction

  // days in a month, month 1 to 12
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      4'd2:                    month_len = leap ? 5'd29 : 5'd28;
      default:                 month_len = 5'd31;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/dtp_if.sv @@
`default_nettype none
// character stream: one byte per word, with end-of-string flag
interface dtp_char_if;
  logic                        valid;
  logic                        ready;
  logic [dtp_pkg::CHAR_W-1:0]  char_code;
  logic                        is_last;
  modport source (output valid, char_code, is_last, input ready);
  modport sink   (input valid, char_code, is_last, output ready);
endinterface

// result stream: status and packed value per string
interface dtp_res_if;
  logic                        valid;
  logic                        ready;
  logic [dtp_pkg::STAT_W-1:0]  status;
  logic [dtp_pkg::VALUE_W-1:0] packed_value;
  modport source (output valid, status, packed_value, input ready);
  modport sink   (input valid, status, packed_value, output ready);
endinterface
`default_nettype wire

@@ rtl/dtp_accum.sv @@
`default_nettype none
module dtp_accum (
  input  wire                clk_i,
  input  wire                rst_ni,
  dtp_char_if.sink           chr_i,
  output dtp_pkg::snap_t     snap_o,
  output logic               snap_valid_o,
  input  wire                snap_ready_i
);

  logic [dtp_pkg::POS_W-1:0]                              pos_q, pos_d;
  logic                                                   bad_q, bad_d;
  logic [dtp_pkg::YEAR_DIGITS-1:0][dtp_pkg::DIGIT_W-1:0]  year_q, year_d;
  logic [dtp_pkg::FIELD_W-1:0]  mon_q, mon_d, day_q, day_d, hour_q, hour_d;
  logic [dtp_pkg::FIELD_W-1:0]  min_q, min_d, sec_q, sec_d;
  logic [dtp_pkg::VALUE_W-1:0]  val_q, val_d;
  logic [dtp_pkg::DIGIT_W-1:0]  dig;
  logic                         is_digit;
  logic                         load;
  logic                         accept;
  dtp_pkg::snap_t               snap_q;
  logic                         snap_valid_q;

  // snapshot slot is free or draining this cycle
  assign load        = !snap_valid_q || snap_ready_i;
  assign chr_i.ready = load;
  assign accept      = chr_i.valid && load;

  assign is_digit = chr_i.char_code inside {[dtp_pkg::CH_ZERO:dtp_pkg::CH_NINE]};
  assign dig      = dtp_pkg::DIGIT_W'(chr_i.char_code - dtp_pkg::CH_ZERO);

  // character check and field update for the current place
  always_comb begin
    bad_d  = bad_q;
    year_d = year_q;
    mon_d  = mon_q;
    day_d  = day_q;
    hour_d = hour_q;
    min_d  = min_q;
    sec_d  = sec_q;
    val_d  = val_q;
    if (pos_q >= dtp_pkg::STR_LEN) begin
      bad_d = 1'b1;
    end else begin
      case (pos_q)
        dtp_pkg::POS_DASH1, dtp_pkg::POS_DASH2: begin
          if (chr_i.char_code != dtp_pkg::CH_DASH) bad_d = 1'b1;
        end
        dtp_pkg::POS_SPACE: begin
          if (chr_i.char_code != dtp_pkg::CH_SPACE) bad_d = 1'b1;
        end
        dtp_pkg::POS_COLON1, dtp_pkg::POS_COLON2: begin
          if (chr_i.char_code != dtp_pkg::CH_COLON) bad_d = 1'b1;
        end
        default: begin
          if (!is_digit) begin
            bad_d = 1'b1;
          end else begin
            // the digits in order build the value YYYYMMDDhhmmss as a binary integer
            val_d = dtp_pkg::VALUE_W'(val_q * 47'd10) + dtp_pkg::VALUE_W'(dig);
            if (pos_q <= dtp_pkg::POS_YEAR_E)      year_d[pos_q[1:0]] = dig;
            else if (pos_q <= dtp_pkg::POS_MON_E)  mon_d  = dtp_pkg::push_digit(mon_q, dig);
            else if (pos_q <= dtp_pkg::POS_DAY_E)  day_d  = dtp_pkg::push_digit(day_q, dig);
            else if (pos_q <= dtp_pkg::POS_HOUR_E) hour_d = dtp_pkg::push_digit(hour_q, dig);
            else if (pos_q <= dtp_pkg::POS_MIN_E)  min_d  = dtp_pkg::push_digit(min_q, dig);
            else                                   sec_d  = dtp_pkg::push_digit(sec_q, dig);
          end
        end
      endcase
    end
  end

  // scan state: cleared after the last character of a string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      bad_q  <= 1'b0;
      year_q <= '0;
      mon_q  <= '0;
      day_q  <= '0;
      hour_q <= '0;
      min_q  <= '0;
      sec_q  <= '0;
      val_q  <= '0;
    end else if (accept) begin
      if (chr_i.is_last) begin
        pos_q  <= '0;
        bad_q  <= 1'b0;
        year_q <= '0;
        mon_q  <= '0;
        day_q  <= '0;
        hour_q <= '0;
        min_q  <= '0;
        sec_q  <= '0;
        val_q  <= '0;
      end else begin
        pos_q  <= (pos_q == dtp_pkg::POS_MAX) ? pos_q : pos_q + 5'd1;
        bad_q  <= bad_d;
        year_q <= year_d;
        mon_q  <= mon_d;
        day_q  <= day_d;
        hour_q <= hour_d;
        min_q  <= min_d;
        sec_q  <= sec_d;
        val_q  <= val_d;
      end
    end
  end

  // snapshot register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (load) begin
      snap_valid_q <= chr_i.valid && chr_i.is_last;
    end
  end

  // snapshot payload of a finished string
  always_ff @(posedge clk_i) begin
    if (accept && chr_i.is_last) begin
      snap_q.fmt_bad  <= bad_d || (pos_q != dtp_pkg::POS_LAST);
      snap_q.year_dig <= year_d;
      snap_q.month    <= mon_d;
      snap_q.day      <= day_d;
      snap_q.hour     <= hour_d;
      snap_q.minute   <= min_d;
      snap_q.second   <= sec_d;
      snap_q.value    <= val_d;
    end
  end

  assign snap_o       = snap_q;
  assign snap_valid_o = snap_valid_q;

endmodule
`default_nettype wire

@@ rtl/dtp_judge.sv @@
`default_nettype none
module dtp_judge (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire dtp_pkg::snap_t snap_i,
  input  wire                snap_valid_i,
  output logic               snap_ready_o,
  dtp_res_if.source          res_o
);

  logic [1:0]                   yy_mod4;
  logic [1:0]                   cc_mod4;
  logic                         yy_zero;
  logic                         leap;
  logic [4:0]                   mdays;
  dtp_pkg::status_e             status;
  logic                         load;
  logic                         out_valid_q;
  dtp_pkg::status_e             status_q;
  logic [dtp_pkg::VALUE_W-1:0]  value_q;

  // leap year from the digits: 10a+b is 2a+b modulo 4
  assign yy_mod4 = 2'({snap_i.year_dig[2][0], 1'b0}) + snap_i.year_dig[3][1:0];
  assign cc_mod4 = 2'({snap_i.year_dig[0][0], 1'b0}) + snap_i.year_dig[1][1:0];
  assign yy_zero = (snap_i.year_dig[2] == '0) && (snap_i.year_dig[3] == '0);
  assign leap    = yy_zero ? (cc_mod4 == 2'd0) : (yy_mod4 == 2'd0);
  assign mdays   = dtp_pkg::month_len(snap_i.month[3:0], leap);

  // checks in priority order
  always_comb begin
    if (snap_i.fmt_bad) begin
      status = dtp_pkg::ST_FORMAT;
    end else if (snap_i.year_dig[0] == '0) begin
      status = dtp_pkg::ST_YEAR;
    end else if (snap_i.month == '0 || snap_i.month > dtp_pkg::MONTH_MAX) begin
      status = dtp_pkg::ST_MONTH;
    end else if (snap_i.day == '0 || snap_i.day > 7'(mdays)) begin
      status = dtp_pkg::ST_DAY;
    end else if (snap_i.hour > dtp_pkg::HOUR_MAX || snap_i.minute > dtp_pkg::MINSEC_MAX
                 || snap_i.second > dtp_pkg::MINSEC_MAX) begin
      status = dtp_pkg::ST_TIME;
    end else begin
      status = dtp_pkg::ST_OK;
    end
  end

  assign load         = !out_valid_q || res_o.ready;
  assign snap_ready_o = load;

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= snap_valid_i;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (load && snap_valid_i) begin
      status_q <= status;
      value_q  <= (status == dtp_pkg::ST_OK) ? snap_i.value : '0;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = status_q;
  assign res_o.packed_value = value_q;

endmodule
`default_nettype wire

@@ rtl/datetime_string_parser.sv @@
`default_nettype none
// Datetime string parser.
// chr_i carries a text string one byte per word, is_last flagging the
// final byte. Each string is checked against YYYY-MM-DD hh:mm:ss (exactly
// 19 bytes) and its calendar values are validated; res_o then carries one
// word per string: status (ok, format, year, month, day, time error) and
// the value YYYYMMDDhhmmss as a binary integer, zero on any error.
// Bytes without is_last produce no output word.
// Throughput: one byte per cycle while chr_i.ready is high. The scan stage
// updates its field accumulators from the incoming byte; the last byte loads
// a snapshot register, the checker then loads the result register.
// The snapshot loads at the edge that accepts the last byte; the checker
// then moves it into the result register, which drives res_o.
// Reset clears the scan position, the accumulators and both valid flags;
// no output word is pending afterwards.
// When the receiver stalls, the result is held in its register, a second
// finished string waits in the snapshot register, and chr_i.ready drops
// only while both are full.
module datetime_string_parser (
  input  wire       clk_i,
  input  wire       rst_ni,
  dtp_char_if.sink  chr_i,
  dtp_res_if.source res_o
);

  dtp_pkg::snap_t snap;
  logic           snap_valid;
  logic           snap_ready;

  dtp_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chr_i        (chr_i),
    .snap_o       (snap),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready)
  );

  dtp_judge u_judge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_i       (snap),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .res_o        (res_o)
  );

  // a valid datetime never packs to zero
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status == dtp_pkg::ST_OK |-> res_o.packed_value != '0)
    else $error("ok result with zero value");

  // errors carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status != dtp_pkg::ST_OK |-> res_o.packed_value == '0)
    else $error("error result with nonzero value");

  // the last byte of a string always lands in the snapshot
  a_last_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chr_i.valid && chr_i.ready && chr_i.is_last |=> snap_valid)
    else $error("finished string lost");

  // a stalled snapshot holds its contents
  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid && !snap_ready |=> snap_valid && $stable(snap))
    else $error("snapshot changed while stalled");

endmodule
`default_nettype wire

@@ tb/tb_datetime_string_parser.sv @@
`default_nettype none
module tb_datetime_string_parser;

  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_PRINTS  = 40;

  typedef struct {
    dtp_pkg::status_e            status;
    logic [dtp_pkg::VALUE_W-1:0] value;
  } dt_result_t;

  logic clk_i;
  logic rst_ni;

  dtp_char_if chr_if ();
  dtp_res_if  res_if ();

  datetime_string_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .chr_i  (chr_if),
    .res_o  (res_if)
  );

  // predictor state: scan position, format flag and decimal fields
  logic [dtp_pkg::POS_W-1:0]   scan_pos;
  bit                          scan_bad;
  logic [13:0]                 year_acc;
  logic [dtp_pkg::FIELD_W-1:0] mon_acc;
  logic [dtp_pkg::FIELD_W-1:0] day_acc;
  logic [dtp_pkg::FIELD_W-1:0] hour_acc;
  logic [dtp_pkg::FIELD_W-1:0] min_acc;
  logic [dtp_pkg::FIELD_W-1:0] sec_acc;
  int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  dt_result_t                  pending_results [$];
  logic [dtp_pkg::CHAR_W-1:0]  tx_text [$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned chars_accepted;
  int unsigned strings_sent;
  int unsigned results_checked;
  int unsigned input_stall_cycles;
  int unsigned status_seen [6];
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned rx_hold_cycles;

  // free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycle_count,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    // keep the log short on a broken block, but count every mismatch
    if (mismatch_count < MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic void clear_scan();
    scan_pos = '0;
    scan_bad = 1'b0;
    year_acc = '0;
    mon_acc  = '0;
    day_acc  = '0;
    hour_acc = '0;
    min_acc  = '0;
    sec_acc  = '0;
  endfunction

  // separator and digit check for one character, digits shifted into their field
  function automatic void take_char(input logic [dtp_pkg::CHAR_W-1:0] c,
                                    input logic [dtp_pkg::POS_W-1:0] p);
    logic [dtp_pkg::DIGIT_W-1:0] d;
    d = dtp_pkg::DIGIT_W'(c - dtp_pkg::CH_ZERO);
    if (p >= dtp_pkg::STR_LEN) begin
      scan_bad = 1'b1;
    end else if (p == dtp_pkg::POS_DASH1 || p == dtp_pkg::POS_DASH2) begin
      if (c != dtp_pkg::CH_DASH) scan_bad = 1'b1;
    end else if (p == dtp_pkg::POS_SPACE) begin
      if (c != dtp_pkg::CH_SPACE) scan_bad = 1'b1;
    end else if (p == dtp_pkg::POS_COLON1 || p == dtp_pkg::POS_COLON2) begin
      if (c != dtp_pkg::CH_COLON) scan_bad = 1'b1;
    end else if (c < dtp_pkg::CH_ZERO || c > dtp_pkg::CH_NINE) begin
      scan_bad = 1'b1;
    end else if (p <= dtp_pkg::POS_YEAR_E) begin
      year_acc = 14'(year_acc * 14'd10 + d);
    end else if (p <= dtp_pkg::POS_MON_E) begin
      mon_acc = dtp_pkg::FIELD_W'(mon_acc * 7'd10 + d);
    end else if (p <= dtp_pkg::POS_DAY_E) begin
      day_acc = dtp_pkg::FIELD_W'(day_acc * 7'd10 + d);
    end else if (p <= dtp_pkg::POS_HOUR_E) begin
      hour_acc = dtp_pkg::FIELD_W'(hour_acc * 7'd10 + d);
    end else if (p <= dtp_pkg::POS_MIN_E) begin
      min_acc = dtp_pkg::FIELD_W'(min_acc * 7'd10 + d);
    end else begin
      sec_acc = dtp_pkg::FIELD_W'(sec_acc * 7'd10 + d);
    end
  endfunction

  // first failing check wins: format, year, month, day, time
  function automatic dtp_pkg::status_e judge_fields(input logic [dtp_pkg::POS_W-1:0] p);
    int unsigned mdays;
    bit          leap;
    if (scan_bad || p != dtp_pkg::POS_LAST) return dtp_pkg::ST_FORMAT;
    if (year_acc < 1000 || year_acc > 9999) return dtp_pkg::ST_YEAR;
    if (mon_acc < 1 || mon_acc > 12) return dtp_pkg::ST_MONTH;
    mdays = month_days[mon_acc - 1];
    leap  = ((year_acc % 4) == 0 && (year_acc % 100) != 0) || (year_acc % 400) == 0;
    if (mon_acc == 2 && leap) mdays = 29;
    if (day_acc < 1 || day_acc > mdays) return dtp_pkg::ST_DAY;
    if (hour_acc > 23 || min_acc > 59 || sec_acc > 59) return dtp_pkg::ST_TIME;
    return dtp_pkg::ST_OK;
  endfunction

  // one accepted character: update fields, on the last one queue the packed date
  task automatic scan_datetime_char(input logic [dtp_pkg::CHAR_W-1:0] c, input logic last);
    logic [dtp_pkg::POS_W-1:0] p;
    logic [63:0]               v;
    dt_result_t                r;
    p = scan_pos;
    take_char(c, p);
    if (!last) begin
      scan_pos = (p < dtp_pkg::POS_MAX) ? p + 1'b1 : dtp_pkg::POS_MAX;
    end else begin
      r.status = judge_fields(p);
      v = '0;
      if (r.status == dtp_pkg::ST_OK) begin
        v = 64'(year_acc) * 64'd10000000000 + 64'(mon_acc) * 64'd100000000
          + 64'(day_acc) * 64'd1000000 + 64'(hour_acc) * 64'd10000
          + 64'(min_acc) * 64'd100 + 64'(sec_acc);
      end
      r.value = v[dtp_pkg::VALUE_W-1:0];
      pending_results = {pending_results, r};
      clear_scan();
    end
  endtask

  task automatic check_result(input logic [dtp_pkg::STAT_W-1:0] st,
                              input logic [dtp_pkg::VALUE_W-1:0] val);
    dt_result_t w;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("word with nothing pending: status %0d value %0d", st, val));
    end else begin
      w = pending_results.pop_front();
      if (st !== w.status)
        report_mismatch($sformatf("status got %0d want %0d", st, w.status));
      if (val !== w.value)
        report_mismatch($sformatf("packed_value got %0d want %0d", val, w.value));
      if (w.status <= dtp_pkg::ST_TIME) status_seen[w.status]++;
      results_checked++;
    end
  endtask

  // watch both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (chr_if.valid && chr_if.ready) begin
        chars_accepted++;
        scan_datetime_char(chr_if.char_code, chr_if.is_last);
      end
      if (chr_if.valid && !chr_if.ready) input_stall_cycles++;
      if (res_if.valid && res_if.ready) check_result(res_if.status, res_if.packed_value);
    end
  end

  // result receiver: random stall per word, plus a long hold on request
  initial begin
    bit          took;
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      took = res_if.valid && res_if.ready;
      @(negedge clk_i);
      if (took) stall_left = rx_idle_en ? $urandom_range(0, 12) : 0;
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        res_if.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // offer one character word; entered and left at a falling edge
  task automatic send_char(input logic [dtp_pkg::CHAR_W-1:0] c, input logic last);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      chr_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    chr_if.valid     = 1'b1;
    chr_if.char_code = c;
    chr_if.is_last   = last;
    do @(posedge clk_i); while (!chr_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_string();
    for (int i = 0; i < tx_text.size(); i++) send_char(tx_text[i], i == tx_text.size() - 1);
    strings_sent++;
  endtask

  task automatic load_text(input string s);
    tx_text.delete();
    for (int i = 0; i < s.len(); i++) tx_text = {tx_text, s[i]};
  endtask

  task automatic send_text(input string s);
    load_text(s);
    send_string();
  endtask

  // mostly digits and separators, otherwise any byte
  function automatic logic [dtp_pkg::CHAR_W-1:0] random_char();
    string alphabet;
    alphabet = "0123456789-: ";
    if ($urandom_range(0, 1)) return alphabet[$urandom_range(0, 12)];
    return dtp_pkg::CHAR_W'($urandom_range(0, 255));
  endfunction

  // well-formed text with field values biased towards the calendar edges
  task automatic make_random_datetime();
    int unsigned y, mo, d, h, mi, s;
    case ($urandom_range(0, 5))
      0:       y = $urandom_range(0, 9999);
      1:       y = $urandom_range(3, 24) * 400;
      2:       y = $urandom_range(10, 99) * 100;
      3:       y = $urandom_range(250, 2499) * 4;
      4:       y = ($urandom_range(0, 1) ? 999 : 1000) + ($urandom_range(0, 1) ? 9000 : 0);
      default: y = $urandom_range(1000, 9999);
    endcase
    mo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    case ($urandom_range(0, 7))
      0:       d = $urandom_range(0, 99);
      1, 2:    d = $urandom_range(28, 31);
      default: d = $urandom_range(1, 31);
    endcase
    h  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 24);
    mi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
    s  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
    load_text($sformatf("%04d-%02d-%02d %02d:%02d:%02d", y % 10000, mo, d, h, mi, s));
  endtask

  task automatic make_random_string();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      // pure noise of any length, past the saturation point too
      tx_text.delete();
      n = $urandom_range(1, 40);
      repeat (n) tx_text = {tx_text, random_char()};
    end else begin
      make_random_datetime();
      if (kind == 7) begin
        tx_text[$urandom_range(0, tx_text.size() - 1)] = dtp_pkg::CHAR_W'($urandom_range(0, 255));
      end else if (kind == 8) begin
        n = $urandom_range(1, 18);
        if ($urandom_range(0, 1)) repeat (n) void'(tx_text.pop_back());
        else repeat (n) tx_text = {tx_text, random_char()};
      end
    end
  endtask

  // calendar and format corners, one string each
  task automatic test_directed_strings();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_text("1000-01-01 00:00:00");
    send_text("9999-12-31 23:59:59");
    send_text("2000-02-29 12:34:56");
    send_text("1900-02-29 12:00:00");
    send_text("2024-02-29 08:00:00");
    send_text("2023-02-29 08:00:00");
    send_text("0999-05-05 05:05:05");
    send_text("2023-00-10 10:10:10");
    send_text("2023-13-01 10:10:10");
    send_text("9999-99-99 99:99:99");
    send_text("2023-04-31 10:10:10");
    send_text("2023-01-00 10:10:10");
    send_text("2023-01-32 10:10:10");
    send_text("2023-01-01 24:00:00");
    send_text("2023-01-01 23:60:00");
    send_text("2023-01-01 23:59:60");
    // check order: year before month, day and time, and day before time
    send_text("0000-13-32 25:61:61");
    send_text("2023-02-30 25:00:00");
    // wrong separators, characters just outside the digit range, and bytes 00 and FF
    send_text("2023/01/01T10:10:10");
    send_text("2/23-0:-01 10:10:10");
    load_text("2023-01-01 10:10:10");
    tx_text[2] = 8'h00;
    tx_text[15] = 8'hFF;
    send_string();
    // wrong length, and a long string that saturates the position
    send_text("2023-01-01 00:00:0");
    send_text("2023-01-01 00:00:001");
    send_text("1234567890123456789012345678901234567890");
    send_text("7");
  endtask

  // hold the result side while strings keep arriving, so the input stalls
  task automatic test_output_backpressure();
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b0;
    rx_hold_cycles = 250;
    send_text("2012-06-15 18:45:30");
    send_text("1999-12-31 23:59:59");
    for (int i = 0; i < 6; i++) send_text("x");
    send_text("2400-02-29 00:00:01");
    send_text("2100-02-29 00:00:01");
  endtask

  // random strings, mostly well-formed, with idling switched per string
  task automatic test_random_strings();
    while (chars_accepted < ITEM_TARGET) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      make_random_string();
      send_string();
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    chr_if.valid     = 1'b0;
    chr_if.char_code = '0;
    chr_if.is_last   = 1'b0;
    res_if.ready     = 1'b0;
    tx_idle_en       = 1'b0;
    rx_idle_en       = 1'b0;
    rx_hold_cycles   = 0;
    clear_scan();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_strings();
    test_output_backpressure();
    test_random_strings();
    chr_if.valid = 1'b0;

    // drain, then a few more cycles to catch stray words
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("run covered %0d strings of %0d characters, %0d result words checked,",
             strings_sent, chars_accepted, results_checked);
    $display("%0d cycles of input stall; outcomes: ok %0d, format %0d, year %0d,",
             input_stall_cycles, status_seen[dtp_pkg::ST_OK],
             status_seen[dtp_pkg::ST_FORMAT], status_seen[dtp_pkg::ST_YEAR]);
    $display("month %0d, day %0d, time %0d",
             status_seen[dtp_pkg::ST_MONTH], status_seen[dtp_pkg::ST_DAY],
             status_seen[dtp_pkg::ST_TIME]);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
